// ===== rtl/bfmp_pkg.sv =====
// Package: shared constants and types for the fill meeting point block.
`default_nettype none
package bfmp_pkg;
  localparam int MAX_ROWS      = 64;
  localparam int MAX_COLS      = 64;
  localparam int WALL_LIST_LEN = 4;
  localparam int ROW_W         = $clog2(MAX_ROWS);
  localparam int COL_W         = $clog2(MAX_COLS);
  localparam int ADDR_W        = ROW_W + COL_W;
  localparam int CHAR_W        = 8;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 8;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WALL_CHAR_A  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WALL_CHAR_B  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WALL_CHAR_C  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WALL_CHAR_D  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WALL_COUNT   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LIST_IS_OPEN = 3'd7;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef struct packed {
    logic [WALL_LIST_LEN-1:0][CHAR_W-1:0] chars;
    logic [2:0]                           count;
    logic                                 list_open;
  } wall_cfg_t;
endpackage
`default_nettype wire

// ===== rtl/bfmp_if.sv =====
// Interfaces: input and result channels with valid/ready handshake.
`default_nettype none
interface bfmp_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [5:0] row_a;
  logic [5:0] col_a;
  logic [5:0] row_b;
  logic [5:0] col_b;
  logic [7:0] cell_char;
  modport source (output valid, operation, row_a, col_a, row_b, col_b, cell_char,
                  input ready);
  modport sink (input valid, operation, row_a, col_a, row_b, col_b, cell_char,
                output ready);
endinterface

interface bfmp_out_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [5:0] meet_row;
  logic [5:0] meet_col;
  modport source (output valid, found, meet_row, meet_col, input ready);
  modport sink (input valid, found, meet_row, meet_col, output ready);
endinterface
`default_nettype wire

// ===== rtl/bfmp_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
`default_nettype none
module bfmp_ram #(
  parameter int DW = 8,
  parameter int AW = 12
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/bfmp_wall.sv =====
// Cell classifier: open or wall under the configured character list.
`default_nettype none
module bfmp_wall (
  input  wire logic [bfmp_pkg::CHAR_W-1:0] ch,
  input  wire bfmp_pkg::wall_cfg_t         cfg,
  output logic                             is_open
);
  logic listed;

  always_comb begin
    listed = 1'b0;
    for (int k = 0; k < bfmp_pkg::WALL_LIST_LEN; k++) begin
      if ((cfg.count > 3'(k)) && (cfg.chars[k] == ch)) begin
        listed = 1'b1;
      end
    end
    is_open = cfg.list_open ? listed : !listed;
  end
endmodule
`default_nettype wire

// ===== rtl/bidirectional_fill_meeting_point_core.sv =====
// Top level: config registers, search sequencer, grid and reach memories.
// Cell write: accepted while idle; the next item may follow the cycle after.
// Search: clears the reach memory, marks the endpoints, sweeps the grid
// until the fills meet or a sweep adds nothing, then loads the result;
// per cell: nine neighbor reads on the single reach port, compare/write.
// Reset clears control and config; grid memory is not cleared.
`default_nettype none
module bidirectional_fill_meeting_point_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wen,
  input  wire logic [bfmp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bfmp_pkg::CFG_DATA_W-1:0] cfg_data,
  bfmp_in_if.sink                             in_ch,
  bfmp_out_if.source                          out_ch
);
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CLEAR  = 3'd1;
  localparam logic [2:0] ST_MARK_S = 3'd2;
  localparam logic [2:0] ST_MARK_G = 3'd3;
  localparam logic [2:0] ST_CELL   = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;
  localparam logic [3:0] PH_LAST   = 4'd10;

  localparam int RW = bfmp_pkg::ROW_W;
  localparam int CW = bfmp_pkg::COL_W;
  localparam int AW = bfmp_pkg::ADDR_W;

  logic [6:0] grid_rows, grid_cols;
  bfmp_pkg::wall_cfg_t wall_cfg;
  logic [6:0] nr, nc;

  logic [2:0] state;
  logic [AW-1:0] clr;
  logic [RW-1:0] ra, rb, cur_r, hit_r;
  logic [CW-1:0] ca, cb, cur_c, hit_c;
  logic [3:0] ph;
  logic changed, hit_f;
  logic acc_s, acc_g, self_s, self_g, vld_q, ctr_q;
  logic [bfmp_pkg::CHAR_W-1:0] char_q;

  logic out_valid, out_found;
  logic [RW-1:0] out_row;
  logic [CW-1:0] out_col;

  logic cwe;
  logic [bfmp_pkg::CHAR_W-1:0] crdata;
  logic rwe;
  logic [AW-1:0] rwaddr, rraddr;
  logic [1:0] rwdata, rrdata;
  logic is_open;

  logic [1:0] dr, dc;
  logic [7:0] nbr_r, nbr_c;
  logic nbr_ok;
  logic can_s, can_g, hit1, hit2, new_s, new_g;
  logic last_c, last_r, same_ep, ep_out;
  logic accept;

  assign nr = (grid_rows > 7'(bfmp_pkg::MAX_ROWS)) ? 7'(bfmp_pkg::MAX_ROWS) : grid_rows;
  assign nc = (grid_cols > 7'(bfmp_pkg::MAX_COLS)) ? 7'(bfmp_pkg::MAX_COLS) : grid_cols;

  assign in_ch.ready = (state == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign cwe         = accept && (in_ch.operation == bfmp_pkg::OP_WRITE);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= 7'd64;
      grid_cols <= 7'd64;
      wall_cfg  <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        bfmp_pkg::REG_GRID_ROWS:    grid_rows <= cfg_data[6:0];
        bfmp_pkg::REG_GRID_COLS:    grid_cols <= cfg_data[6:0];
        bfmp_pkg::REG_WALL_CHAR_A:  wall_cfg.chars[0] <= cfg_data;
        bfmp_pkg::REG_WALL_CHAR_B:  wall_cfg.chars[1] <= cfg_data;
        bfmp_pkg::REG_WALL_CHAR_C:  wall_cfg.chars[2] <= cfg_data;
        bfmp_pkg::REG_WALL_CHAR_D:  wall_cfg.chars[3] <= cfg_data;
        bfmp_pkg::REG_WALL_COUNT:   wall_cfg.count <= cfg_data[2:0];
        bfmp_pkg::REG_LIST_IS_OPEN: wall_cfg.list_open <= cfg_data[0];
        default: ;
      endcase
    end
  end

  bfmp_ram #(.DW(bfmp_pkg::CHAR_W), .AW(AW)) u_grid (
    .clk   (clk),
    .we    (cwe),
    .waddr ({in_ch.row_a, in_ch.col_a}),
    .wdata (in_ch.cell_char),
    .raddr ({cur_r, cur_c}),
    .rdata (crdata)
  );

  bfmp_ram #(.DW(2), .AW(AW)) u_reach (
    .clk   (clk),
    .we    (rwe),
    .waddr (rwaddr),
    .wdata (rwdata),
    .raddr (rraddr),
    .rdata (rrdata)
  );

  bfmp_wall u_wall (
    .ch      (char_q),
    .cfg     (wall_cfg),
    .is_open (is_open)
  );

  // neighbor offset per read phase, row-major over the 3x3 window
  always_comb begin
    unique case (ph)
      4'd0, 4'd1, 4'd2: dr = 2'd0;
      4'd3, 4'd4, 4'd5: dr = 2'd1;
      default:          dr = 2'd2;
    endcase
    unique case (ph)
      4'd0, 4'd3, 4'd6: dc = 2'd0;
      4'd1, 4'd4, 4'd7: dc = 2'd1;
      default:          dc = 2'd2;
    endcase
    nbr_r  = 8'(cur_r) + 8'(dr) - 8'd1;
    nbr_c  = 8'(cur_c) + 8'(dc) - 8'd1;
    nbr_ok = (nbr_r < 8'(nr)) && (nbr_c < 8'(nc)) && (ph <= 4'd8);
    rraddr = {nbr_r[RW-1:0], nbr_c[CW-1:0]};
  end

  always_comb begin
    can_s  = !self_s && is_open && acc_s;
    new_s  = self_s || can_s;
    hit1   = can_s && self_g;
    can_g  = !hit1 && !self_g && is_open && acc_g;
    new_g  = self_g || can_g;
    hit2   = can_g && new_s;
    last_c = (7'(cur_c) == nc - 7'd1);
    last_r = (7'(cur_r) == nr - 7'd1);
    same_ep = (ra == rb) && (ca == cb);
    ep_out = (7'(in_ch.row_a) >= nr) || (7'(in_ch.col_a) >= nc) ||
             (7'(in_ch.row_b) >= nr) || (7'(in_ch.col_b) >= nc);
  end

  always_comb begin
    rwe    = 1'b0;
    rwaddr = clr;
    rwdata = 2'b00;
    unique case (state)
      ST_CLEAR: rwe = 1'b1;
      ST_MARK_S: begin
        rwe    = 1'b1;
        rwaddr = {ra, ca};
        rwdata = same_ep ? 2'b11 : 2'b01;
      end
      ST_MARK_G: begin
        rwe    = 1'b1;
        rwaddr = {rb, cb};
        rwdata = 2'b10;
      end
      ST_CELL: begin
        rwe    = (ph == PH_LAST);
        rwaddr = {cur_r, cur_c};
        rwdata = {new_g, new_s};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    vld_q <= (state == ST_CELL) && nbr_ok;
    ctr_q <= (state == ST_CELL) && (ph == 4'd4);
    if (ph == 4'd0) begin
      acc_s <= 1'b0;
      acc_g <= 1'b0;
    end else if (vld_q) begin
      acc_s <= acc_s | rrdata[0];
      acc_g <= acc_g | rrdata[1];
    end
    if (ctr_q) begin
      self_s <= rrdata[0];
      self_g <= rrdata[1];
    end
    if (ph == 4'd1) begin
      char_q <= crdata;
    end
    if (accept) begin
      ra <= in_ch.row_a;
      ca <= in_ch.col_a;
      rb <= in_ch.row_b;
      cb <= in_ch.col_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      clr       <= '0;
      cur_r     <= '0;
      cur_c     <= '0;
      ph        <= '0;
      changed   <= 1'b0;
      hit_f     <= 1'b0;
      hit_r     <= '0;
      hit_c     <= '0;
      out_valid <= 1'b0;
      out_found <= 1'b0;
      out_row   <= '0;
      out_col   <= '0;
    end else begin
      if (out_valid && out_ch.ready && (state != ST_FINISH)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && (in_ch.operation == bfmp_pkg::OP_SEARCH)) begin
            hit_f <= 1'b0;
            hit_r <= '0;
            hit_c <= '0;
            clr   <= '0;
            state <= ep_out ? ST_FINISH : ST_CLEAR;
          end
        end
        ST_CLEAR: begin
          clr <= clr + AW'(1);
          if (&clr) begin
            state <= ST_MARK_S;
          end
        end
        ST_MARK_S: begin
          cur_r   <= '0;
          cur_c   <= '0;
          ph      <= '0;
          changed <= 1'b0;
          state   <= same_ep ? ST_CELL : ST_MARK_G;
        end
        ST_MARK_G: state <= ST_CELL;
        ST_CELL: begin
          if (ph != PH_LAST) begin
            ph <= ph + 4'd1;
          end else begin
            ph <= '0;
            if (hit1 || hit2) begin
              hit_f <= 1'b1;
              hit_r <= cur_r;
              hit_c <= cur_c;
              state <= ST_FINISH;
            end else if (!last_c) begin
              cur_c   <= cur_c + CW'(1);
              changed <= changed | can_s | can_g;
            end else if (!last_r) begin
              cur_c   <= '0;
              cur_r   <= cur_r + RW'(1);
              changed <= changed | can_s | can_g;
            end else if (changed || can_s || can_g) begin
              cur_c   <= '0;
              cur_r   <= '0;
              changed <= 1'b0;
            end else begin
              state <= ST_FINISH;
            end
          end
        end
        ST_FINISH: begin
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            out_found <= hit_f;
            out_row   <= hit_r;
            out_col   <= hit_c;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid    = out_valid;
  assign out_ch.found    = out_found;
  assign out_ch.meet_row = out_row;
  assign out_ch.meet_col = out_col;

  a_hit_in_grid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_found) |-> ((7'(out_row) < nr) && (7'(out_col) < nc)))
    else $error("meeting cell outside grid");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_found) |-> ((out_row == '0) && (out_col == '0)))
    else $error("not found result with nonzero coordinates");

  a_clear_steps: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR && clr != '0) |-> (clr == $past(clr) + AW'(1)))
    else $error("clear pass skipped an entry");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CELL) |-> (ph <= PH_LAST))
    else $error("cell phase out of range");
endmodule
`default_nettype wire

// ===== test/bidirectional_fill_meeting_point_core_test.sv =====
// Testbench: checks found/meet cell of the fill meeting point core against a local flood fill.
`timescale 1ns / 100ps
module bidirectional_fill_meeting_point_core_test;

  typedef struct {
    logic       op;
    logic [5:0] ra, ca, rb, cb;
    logic [7:0] ch;
  } cell_cmd_t;

  typedef struct {
    logic       found;
    logic [5:0] row, col;
  } meet_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wen = 1'b0;
  logic [bfmp_pkg::CFG_IDX_W-1:0] cfg_index = bfmp_pkg::REG_GRID_ROWS;
  logic [bfmp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  bfmp_in_if in_ch ();
  bfmp_out_if out_ch ();

  bidirectional_fill_meeting_point_core dut (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // local copy of block state and config
  logic [7:0] grid_chars [bfmp_pkg::MAX_ROWS][bfmp_pkg::MAX_COLS];
  bit         fwd_mark [bfmp_pkg::MAX_ROWS][bfmp_pkg::MAX_COLS];
  bit         bwd_mark [bfmp_pkg::MAX_ROWS][bfmp_pkg::MAX_COLS];
  int unsigned rows_cfg = 64, cols_cfg = 64, wall_cnt = 0;
  logic [7:0] wall_chars [4] = '{8'h00, 8'h00, 8'h00, 8'h00};
  bit         only_listed_open = 0;

  cell_cmd_t pending_cmds [$];
  meet_t     meet_expect [$];
  int        mismatch_count = 0, items_sent = 0, searches_checked = 0, meets_seen = 0;
  int        in_gap = 0, out_stall = 0;
  bit        in_took = 0, out_took = 0, in_burst = 0, out_burst = 0;

  initial forever #2 clk = ~clk;

  initial begin
    #1_000_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int draw_wait(input bit burst);
    return burst ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic bit char_open(input logic [7:0] ch);
    int  n;
    bit  listed;
    n = wall_cnt > bfmp_pkg::WALL_LIST_LEN ? bfmp_pkg::WALL_LIST_LEN : wall_cnt;
    listed = 0;
    for (int k = 0; k < n; k++) if (wall_chars[k] == ch) listed = 1;
    return only_listed_open ? listed : !listed;
  endfunction

  function automatic bit can_grow(input bit goal_side, input int r, input int c,
                                  input int nr, input int nc);
    bit near;
    bit here;
    near = 0;
    here = goal_side ? bwd_mark[r][c] : fwd_mark[r][c];
    if (here || !char_open(grid_chars[r][c])) return 0;
    for (int dr = -1; dr <= 1; dr++)
      for (int dc = -1; dc <= 1; dc++)
        if (r + dr >= 0 && r + dr < nr && c + dc >= 0 && c + dc < nc)
          if (goal_side ? bwd_mark[r+dr][c+dc] : fwd_mark[r+dr][c+dc]) near = 1;
    return near;
  endfunction

  function automatic meet_t find_meeting(input cell_cmd_t cmd);
    meet_t m;
    int    nr, nc;
    bit    changed, hit;
    m = '{1'b0, 6'd0, 6'd0};
    nr = rows_cfg > bfmp_pkg::MAX_ROWS ? bfmp_pkg::MAX_ROWS : rows_cfg;
    nc = cols_cfg > bfmp_pkg::MAX_COLS ? bfmp_pkg::MAX_COLS : cols_cfg;
    foreach (fwd_mark[i, j]) begin
      fwd_mark[i][j] = 0;
      bwd_mark[i][j] = 0;
    end
    if (cmd.ra >= nr || cmd.ca >= nc || cmd.rb >= nr || cmd.cb >= nc) return m;
    fwd_mark[cmd.ra][cmd.ca] = 1;
    bwd_mark[cmd.rb][cmd.cb] = 1;
    do begin
      changed = 0;
      for (int i = 0; i < nr; i++)
        for (int j = 0; j < nc; j++) begin
          hit = 0;
          if (can_grow(0, i, j, nr, nc)) begin
            changed = 1;
            fwd_mark[i][j] = 1;
            hit = bwd_mark[i][j];
          end
          if (!hit && can_grow(1, i, j, nr, nc)) begin
            changed = 1;
            bwd_mark[i][j] = 1;
            hit = fwd_mark[i][j];
          end
          if (hit) begin
            m = '{1'b1, 6'(i), 6'(j)};
            return m;
          end
        end
    end while (changed);
    return m;
  endfunction

  // monitor
  always @(posedge clk) begin
    in_took = !rst && in_ch.valid && in_ch.ready;
    out_took = !rst && out_ch.valid && out_ch.ready;
    if (in_took) begin
      cell_cmd_t cmd;
      cmd = '{in_ch.operation, in_ch.row_a, in_ch.col_a, in_ch.row_b, in_ch.col_b,
              in_ch.cell_char};
      if (cmd.op == bfmp_pkg::OP_WRITE) grid_chars[cmd.ra][cmd.ca] = cmd.ch;
      else meet_expect.push_back(find_meeting(cmd));
    end
    if (out_took) begin
      if (meet_expect.size() == 0) begin
        $error("result transfer with nothing expected");
        mismatch_count++;
      end else begin
        meet_t e;
        e = meet_expect.pop_front();
        searches_checked++;
        if (out_ch.found) meets_seen++;
        if (out_ch.found !== e.found) begin
          $error("found: expected %0d actual %0d", e.found, out_ch.found);
          mismatch_count++;
        end
        if (out_ch.meet_row !== e.row) begin
          $error("meet_row: expected %0d actual %0d", e.row, out_ch.meet_row);
          mismatch_count++;
        end
        if (out_ch.meet_col !== e.col) begin
          $error("meet_col: expected %0d actual %0d", e.col, out_ch.meet_col);
          mismatch_count++;
        end
      end
    end
  end

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (in_took) begin
        if ($urandom_range(0, 19) == 0) in_burst = !in_burst;
        in_gap = draw_wait(in_burst);
      end
      if (in_ch.valid && !in_took) begin
      end else if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        cell_cmd_t cmd;
        cmd = pending_cmds.pop_front();
        in_ch.operation <= cmd.op;
        in_ch.row_a <= cmd.ra;
        in_ch.col_a <= cmd.ca;
        in_ch.row_b <= cmd.rb;
        in_ch.col_b <= cmd.cb;
        in_ch.cell_char <= cmd.ch;
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
      if (out_took) begin
        if ($urandom_range(0, 9) == 0) out_burst = !out_burst;
        out_stall = draw_wait(out_burst);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic push_write(input int r, input int c, input logic [7:0] ch);
    pending_cmds.push_back('{bfmp_pkg::OP_WRITE, 6'(r), 6'(c), 6'($urandom), 6'($urandom),
                             ch});
    items_sent++;
  endtask

  task automatic push_search(input int ra, input int ca, input int rb, input int cb);
    pending_cmds.push_back('{bfmp_pkg::OP_SEARCH, 6'(ra), 6'(ca), 6'(rb), 6'(cb),
                             8'($urandom)});
    items_sent++;
  endtask

  task automatic write_reg(input logic [bfmp_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned val);
    @(negedge clk);
    cfg_wen = 1'b1;
    cfg_index = idx;
    cfg_data = val[bfmp_pkg::CFG_DATA_W-1:0];
    case (idx)
      bfmp_pkg::REG_GRID_ROWS:    rows_cfg = val & 32'h7F;
      bfmp_pkg::REG_GRID_COLS:    cols_cfg = val & 32'h7F;
      bfmp_pkg::REG_WALL_CHAR_A:  wall_chars[0] = val[7:0];
      bfmp_pkg::REG_WALL_CHAR_B:  wall_chars[1] = val[7:0];
      bfmp_pkg::REG_WALL_CHAR_C:  wall_chars[2] = val[7:0];
      bfmp_pkg::REG_WALL_CHAR_D:  wall_chars[3] = val[7:0];
      bfmp_pkg::REG_WALL_COUNT:   wall_cnt = val & 32'h7;
      bfmp_pkg::REG_LIST_IS_OPEN: only_listed_open = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wen = 1'b0;
  endtask

  // sender holds off until the block has drained
  task automatic settle();
    while (pending_cmds.size() > 0 || in_ch.valid || meet_expect.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 7))
      0, 1, 2: return wall_chars[$urandom_range(0, 3)];
      3:       return 8'h00;
      4:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic fill_area();
    int nr, nc;
    nr = rows_cfg > bfmp_pkg::MAX_ROWS ? bfmp_pkg::MAX_ROWS : rows_cfg;
    nc = cols_cfg > bfmp_pkg::MAX_COLS ? bfmp_pkg::MAX_COLS : cols_cfg;
    for (int r = 0; r < nr; r++)
      for (int c = 0; c < nc; c++) push_write(r, c, pick_char());
  endtask

  function automatic int pick_dim();
    case ($urandom_range(0, 15))
      0:       return 0;
      1, 2:    return 1;
      3:       return 64;
      4:       return 127;
      default: return $urandom_range(2, 8);
    endcase
  endfunction

  initial begin
    int nr, nc, phases;
    logic [bfmp_pkg::CFG_IDX_W-1:0] wreg;
    in_ch.valid = 1'b0;
    in_ch.operation = bfmp_pkg::OP_WRITE;
    in_ch.row_a = '0;
    in_ch.col_a = '0;
    in_ch.row_b = '0;
    in_ch.col_b = '0;
    in_ch.cell_char = '0;
    out_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: 4x4 with a wall column open only at the bottom
    write_reg(bfmp_pkg::REG_GRID_ROWS, 4);
    write_reg(bfmp_pkg::REG_GRID_COLS, 4);
    write_reg(bfmp_pkg::REG_WALL_CHAR_A, 8'h23);
    write_reg(bfmp_pkg::REG_WALL_CHAR_B, 8'hFF);
    write_reg(bfmp_pkg::REG_WALL_CHAR_C, 8'h00);
    write_reg(bfmp_pkg::REG_WALL_CHAR_D, 8'h80);
    write_reg(bfmp_pkg::REG_WALL_COUNT, 4);
    write_reg(bfmp_pkg::REG_LIST_IS_OPEN, 0);
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) push_write(r, c, (c == 2 && r != 3) ? 8'h23 : 8'h2E);
    push_search(0, 0, 0, 3);
    push_search(1, 1, 1, 1);
    push_search(4, 0, 0, 0);
    push_search(0, 0, 0, 63);
    push_search(63, 63, 63, 63);
    push_search(0, 2, 3, 3);
    push_write(3, 2, 8'hFF);
    push_search(0, 0, 0, 3);
    settle();
    write_reg(bfmp_pkg::REG_GRID_ROWS, 0);
    push_search(0, 0, 0, 0);
    settle();

    // random phases on small grids and long narrow strips
    phases = 0;
    while (items_sent < 350) begin
      phases++;
      nr = pick_dim();
      nc = pick_dim();
      if (nr > 8 && nc > 3) nc = $urandom_range(1, 3);
      else if (nc > 8 && nr > 3) nr = $urandom_range(1, 3);
      write_reg(bfmp_pkg::REG_GRID_ROWS, nr);
      write_reg(bfmp_pkg::REG_GRID_COLS, nc);
      wreg = bfmp_pkg::REG_WALL_CHAR_A;
      for (int k = 0; k < 4; k++) begin
        write_reg(wreg,
                  $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 255 : 0) : $urandom);
        wreg = wreg + 1'b1;
      end
      write_reg(bfmp_pkg::REG_WALL_COUNT, $urandom_range(0, 7));
      write_reg(bfmp_pkg::REG_LIST_IS_OPEN, $urandom_range(0, 1));
      fill_area();
      nr = rows_cfg > bfmp_pkg::MAX_ROWS ? bfmp_pkg::MAX_ROWS : rows_cfg;
      nc = cols_cfg > bfmp_pkg::MAX_COLS ? bfmp_pkg::MAX_COLS : cols_cfg;
      repeat ($urandom_range(4, 10)) begin
        if ($urandom_range(0, 9) < 3)
          push_write($urandom_range(0, 63), $urandom_range(0, 63), pick_char());
        else if ($urandom_range(0, 9) < 8 && nr > 0 && nc > 0)
          push_search($urandom_range(0, nr - 1), $urandom_range(0, nc - 1),
                      $urandom_range(0, nr - 1), $urandom_range(0, nc - 1));
        else
          push_search($urandom_range(0, 63), $urandom_range(0, 63),
                      $urandom_range(0, 63), $urandom_range(0, 63));
      end
      settle();
    end

    // tall grid with clamped row count, everything open
    write_reg(bfmp_pkg::REG_GRID_ROWS, 127);
    write_reg(bfmp_pkg::REG_GRID_COLS, 2);
    write_reg(bfmp_pkg::REG_WALL_COUNT, 0);
    write_reg(bfmp_pkg::REG_LIST_IS_OPEN, 0);
    fill_area();
    push_search(0, 0, 63, 1);
    push_search(63, 0, 0, 1);
    settle();

    $display("Covered %0d items over %0d random phases plus directed and tall-grid cases;",
             items_sent, phases);
    $display("%0d searches checked, %0d of them met.", searches_checked, meets_seen);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
